// ===== rtl/pl3d_pkg.sv =====
// Package for point_to_line_projection_3d: widths, register indexes, tdata layout.
// No dependencies.
package pl3d_pkg;
  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int DotW   = 68;   // sum of three 33x33 products
  localparam int NumW   = 104;  // 2*|dw|*|d| + dd
  localparam int DenW   = 69;   // 2*dd
  localparam int OffW   = 36;   // |offset| <= |w| max, 35 bits plus margin
  localparam int ErrW   = 37;
  localparam int EsW    = 76;
  localparam int RootW  = 38;
  localparam int InW    = 96;
  localparam int OutW   = 168;  // 32*3 + 31 + 32 + 1 = 160 -> 168 bits

  localparam logic [2:0] RegStartX = 3'd0;
  localparam logic [2:0] RegStartY = 3'd1;
  localparam logic [2:0] RegStartZ = 3'd2;
  localparam logic [2:0] RegEndX   = 3'd3;
  localparam logic [2:0] RegEndY   = 3'd4;
  localparam logic [2:0] RegEndZ   = 3'd5;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [OffW:0] v);
    logic signed [OffW:0] hi, lo;
    hi = (OffW+1)'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - (OffW+1)'(1);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[CoordW-1:0];
  endfunction
endpackage

// ===== rtl/point_to_line_projection_3d.sv =====
// point_to_line_projection_3d: projects a stream of 3D points onto a configured line.
// Depends on pl3d_pkg. Contains the full pipeline: products, dot sums, divider, sqrt.
//
// Usage:
//   cfg channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0..5 = start_x,y,z, end_x,y,z)
//   and cfg_data_i. Ready is always high; writes beyond index 5 are ignored.
//   Write only while the pipeline is empty.
//   s_axis: tdata = point_x [31:0], point_y [63:32], point_z [95:64].
//   m_axis: tdata = foot_x, foot_y, foot_z, perpendicular_distance (31 b),
//   signed_start_distance, degenerate_line, then zero fill to 168 bits.
// Throughput: one point per cycle while m_axis is not stalled. Stages: products, dot sums
// and numerator, a radix-2 restoring divider pipeline (one quotient bit a stage), error
// terms, a square root (two radicand bits a stage), one output register: 149 stages in all.
// The whole pipeline advances only when the output register is free or being
// taken, so a stalled receiver freezes all stages; nothing is lost or repeated.
// Reset clears all valid bits and the line endpoints to zero.
module point_to_line_projection_3d import pl3d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [CoordW-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [InW-1:0]    s_axis_tdata,   // point_x, point_y, point_z
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OutW-1:0]   m_axis_tdata    // foot_x,y,z, perp, sdist, degen
);
  localparam int QN = NumW;
  localparam int SN = RootW;

  logic signed [CoordW-1:0] p1_q [3];
  logic signed [CoordW-1:0] p2_q [3];
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= '0;
        p2_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegStartX: p1_q[0] <= cfg_data_i;
        RegStartY: p1_q[1] <= cfg_data_i;
        RegStartZ: p1_q[2] <= cfg_data_i;
        RegEndX:   p2_q[0] <= cfg_data_i;
        RegEndY:   p2_q[1] <= cfg_data_i;
        RegEndZ:   p2_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: differences and products
  logic signed [DiffW-1:0] d_c [3];
  logic signed [DiffW-1:0] w_c [3];
  logic v1_q;
  logic signed [2*DiffW-1:0] pdd_q [3], pdw_q [3], pww_q [3];
  logic signed [DiffW-1:0] d1_q [3], w1_q [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = DiffW'(p2_q[i]) - DiffW'(p1_q[i]);
      w_c[i] = DiffW'(signed'(s_axis_tdata[i*CoordW +: CoordW])) - DiffW'(p1_q[i]);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pdd_q[i] <= d_c[i] * d_c[i];
        pdw_q[i] <= d_c[i] * w_c[i];
        pww_q[i] <= w_c[i] * w_c[i];
        d1_q[i] <= d_c[i];
        w1_q[i] <= w_c[i];
      end
    end
  end

  // stage 2: dot sums
  logic v2_q;
  logic signed [DotW-1:0] dd_q, dw_q, ww_q;
  logic signed [DiffW-1:0] d2_q [3], w2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q <= DotW'(pdd_q[0]) + DotW'(pdd_q[1]) + DotW'(pdd_q[2]);
      dw_q <= DotW'(pdw_q[0]) + DotW'(pdw_q[1]) + DotW'(pdw_q[2]);
      ww_q <= DotW'(pww_q[0]) + DotW'(pww_q[1]) + DotW'(pww_q[2]);
      d2_q <= d1_q;
      w2_q <= w1_q;
    end
  end

  // stage 3: numerators (|dw|*|d_i| multiplied in 34x34 chunks would be costly;
  // split 68x33 into two 34x33 partial products registered, summed next stage)
  logic [DotW-1:0] dwmag_c;
  logic dwneg_c;
  assign dwneg_c = dw_q[DotW-1];
  assign dwmag_c = dwneg_c ? DotW'(-dw_q) : DotW'(dw_q);
  logic v3_q;
  logic [66:0] plo_q [3], phi_q [3];
  logic [DotW-1:0] dd3_q, ww3_q;
  logic dwneg3_q, dwz3_q;
  logic [2:0] dneg3_q;
  logic signed [DiffW-1:0] w3_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [32:0] dm;
        dm = d2_q[i][DiffW-1] ? 33'(-d2_q[i]) : 33'(d2_q[i]);
        plo_q[i]  <= 67'(dwmag_c[33:0]) * 67'(dm);
        phi_q[i]  <= 67'(dwmag_c[67:34]) * 67'(dm);
        dneg3_q[i] <= d2_q[i][DiffW-1];
      end
      dd3_q <= dd_q;
      ww3_q <= ww_q;
      dwneg3_q <= dwneg_c;
      dwz3_q <= (dw_q == '0);
      w3_q <= w2_q;
    end
  end

  // stage 4: assemble numerator 2*|dw||d| + dd
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] num;
    logic [NumW-1:0] quo;
  } div_t;
  logic v4_q;
  div_t dv_q [3];
  logic [DotW-1:0] dd4_q, ww4_q;
  logic dwneg4_q, dwz4_q;
  logic [2:0] dneg4_q;
  logic signed [DiffW-1:0] w4_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [NumW-1:0] m;
        m = NumW'(plo_q[i]) + (NumW'(phi_q[i]) << 34);
        dv_q[i].num <= (m << 1) + NumW'(dd3_q);
        dv_q[i].rem <= '0;
        dv_q[i].quo <= '0;
      end
      dd4_q <= dd3_q;
      ww4_q <= ww3_q;
      dwneg4_q <= dwneg3_q;
      dwz4_q <= dwz3_q;
      dneg4_q <= dneg3_q;
      w4_q <= w3_q;
    end
  end

  // divider pipeline, one quotient bit per stage
  typedef struct packed {
    logic [DotW-1:0] dd;
    logic [DotW-1:0] ww;
    logic dwneg;
    logic dwz;
    logic [2:0] dneg;
    logic [3*DiffW-1:0] w;
  } side_t;
  logic  dvv_q [QN+1];
  div_t  dvs_q [QN+1][3];
  side_t dsd_q [QN+1];
  always_comb begin
    dvv_q[0] = v4_q;
    dvs_q[0] = dv_q;
    dsd_q[0].dd = dd4_q;
    dsd_q[0].ww = ww4_q;
    dsd_q[0].dwneg = dwneg4_q;
    dsd_q[0].dwz = dwz4_q;
    dsd_q[0].dneg = dneg4_q;
    dsd_q[0].w = {w4_q[2], w4_q[1], w4_q[0]};
  end
  for (genvar s = 0; s < QN; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvv_q[s+1] <= 1'b0;
      else if (adv) dvv_q[s+1] <= dvv_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          logic [NumW:0] r;
          logic [NumW:0] den;
          den = (NumW+1)'({dsd_q[s].dd, 1'b0});
          r = {dvs_q[s][i].rem, dvs_q[s][i].num[NumW-1]};
          if (r >= den) begin
            dvs_q[s+1][i].rem <= NumW'(r - den);
            dvs_q[s+1][i].quo <= {dvs_q[s][i].quo[NumW-2:0], 1'b1};
          end else begin
            dvs_q[s+1][i].rem <= NumW'(r);
            dvs_q[s+1][i].quo <= {dvs_q[s][i].quo[NumW-2:0], 1'b0};
          end
          dvs_q[s+1][i].num <= {dvs_q[s][i].num[NumW-2:0], 1'b0};
        end
        dsd_q[s+1] <= dsd_q[s];
      end
    end
  end

  // error stage A: signed offset, foot, error
  logic degen_c;
  assign degen_c = (dsd_q[QN].dd == '0);
  logic va_q;
  logic signed [CoordW-1:0] foot_q [3];
  logic signed [ErrW-1:0] e_q [3];
  logic [DotW-1:0] wwa_q;
  logic sneg_a_q, degen_a_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= dvv_q[QN];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [OffW:0] off;
        logic signed [DiffW-1:0] wi;
        wi = dsd_q[QN].w[i*DiffW +: DiffW];
        off = (OffW+1)'(signed'({1'b0, dvs_q[QN][i].quo[OffW-1:0]}));
        if (degen_c) off = '0;
        else if (dsd_q[QN].dwneg != dsd_q[QN].dneg[i]) off = -off;
        foot_q[i] <= sat32((OffW+1)'(p1_q[i]) + off);
        e_q[i] <= ErrW'(wi) - ErrW'(off);
      end
      wwa_q <= dsd_q[QN].ww;
      sneg_a_q <= dsd_q[QN].dwneg || dsd_q[QN].dwz;
      degen_a_q <= degen_c;
    end
  end

  // error stage B: squares and sum; |e| stays below 2^34
  logic vb_q;
  logic [EsW-1:0] esq_q [3];
  logic signed [CoordW-1:0] footb_q [3];
  logic [DotW-1:0] wwb_q;
  logic snegb_q, degenb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (adv) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [ErrW-1:0] em;
        em = e_q[i][ErrW-1] ? ErrW'(-e_q[i]) : ErrW'(e_q[i]);
        esq_q[i] <= EsW'(68'(em[33:0]) * 68'(em[33:0]));
      end
      footb_q <= foot_q;
      wwb_q <= wwa_q;
      snegb_q <= sneg_a_q;
      degenb_q <= degen_a_q;
    end
  end

  // square root pipelines, one result bit per stage, two roots side by side
  typedef struct packed {
    logic [2*SN+1:0] rem;
    logic [2*SN-1:0] x;
    logic [SN:0]     res;
  } sq_t;
  typedef struct packed {
    logic [3*CoordW-1:0] foot;
    logic sneg;
    logic degen;
  } sqside_t;
  logic    sv_q [SN+1];
  sq_t     sp_q [SN+1];
  sq_t     sl_q [SN+1];
  sqside_t ss_q [SN+1];
  always_comb begin
    sv_q[0] = vb_q;
    sp_q[0].rem = '0;
    sp_q[0].res = '0;
    sp_q[0].x = (2*SN)'(esq_q[0]) + (2*SN)'(esq_q[1]) + (2*SN)'(esq_q[2]);
    sl_q[0].rem = '0;
    sl_q[0].res = '0;
    sl_q[0].x = (2*SN)'(wwb_q);
    ss_q[0].foot = {footb_q[2], footb_q[1], footb_q[0]};
    ss_q[0].sneg = snegb_q;
    ss_q[0].degen = degenb_q;
  end
  function automatic sq_t sq_step(input sq_t a);
    sq_t o;
    logic [2*SN+1:0] r, t;
    r = {a.rem[2*SN-1:0], a.x[2*SN-1:2*SN-2]};
    t = (2*SN+2)'({a.res, 2'b01});
    o.x = {a.x[2*SN-3:0], 2'b00};
    if (r >= t) begin
      o.rem = r - t;
      o.res = {a.res[SN-1:0], 1'b1};
    end else begin
      o.rem = r;
      o.res = {a.res[SN-1:0], 1'b0};
    end
    return o;
  endfunction
  for (genvar s = 0; s < SN; s++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s+1] <= 1'b0;
      else if (adv) sv_q[s+1] <= sv_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sp_q[s+1] <= sq_step(sp_q[s]);
        sl_q[s+1] <= sq_step(sl_q[s]);
        ss_q[s+1] <= ss_q[s];
      end
    end
  end

  // output register: rounding (remainder > root -> round up) and saturation
  logic [SN:0] pr_c, lr_c;
  logic [30:0] perp_c;
  logic signed [CoordW-1:0] sd_c;
  always_comb begin
    pr_c = sp_q[SN].res + (SN+1)'(sp_q[SN].rem > (2*SN+2)'(sp_q[SN].res));
    lr_c = sl_q[SN].res + (SN+1)'(sl_q[SN].rem > (2*SN+2)'(sl_q[SN].res));
    perp_c = (pr_c > (SN+1)'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : pr_c[30:0];
    if (!ss_q[SN].sneg)
      sd_c = (lr_c > (SN+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : lr_c[31:0];
    else
      sd_c = (lr_c > (SN+1)'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-lr_c[31:0]);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= sv_q[SN];
  end
  always_ff @(posedge clk_i) begin
    if (adv) m_axis_tdata <= {8'd0, ss_q[SN].degen, sd_c, perp_c, ss_q[SN].foot};
  end

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid;
  endproperty
  a_hold: assert property (p_hold) else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready)) else $error("ready mismatch");
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[159] |-> m_axis_tdata[158]
      || m_axis_tdata[158:127] == 32'h0) else $error("degenerate sign wrong");
endmodule
